// ===== hw/rtl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

   localparam int OperandWidthDefault = 32;
   localparam int NumWidth = 64;
   localparam int DenWidth = 62;
   localparam int MagWidth = 63;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_NORM = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_GCD,
      S_DIVN,
      S_DIVD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic sum;
      logic gcd_start;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic div_num;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic early;
      logic gcd_done;
      logic div_done;
   } stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rau_ctrl.sv =====
`default_nettype none
module rau_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_fire,
   input  wire logic           out_busy,
   input  wire rau_pkg::stat_type stat,
   output rau_pkg::ctrl_type   ctrl,
   output logic                idle
);
   import rau_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      idle = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (in_fire) begin
               ctrl.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            ctrl.mul = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            ctrl.sum = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.early) begin
               state_in = S_DONE;
            end else if (stat.gcd_done) begin
               ctrl.div_start = 1'b1;
               state_in = S_DIVN;
            end else begin
               ctrl.gcd_step = 1'b1;
            end
         end
         S_DIVN: begin
            ctrl.div_num = 1'b1;
            if (stat.div_done) begin
               ctrl.div_start = 1'b1;
               state_in = S_DIVD;
            end else begin
               ctrl.div_step = 1'b1;
            end
         end
         S_DIVD: begin
            if (stat.div_done) begin
               state_in = S_DONE;
            end else begin
               ctrl.div_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!out_busy) begin
               ctrl.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ctrl.gcd_start = ctrl.sum;
   end

   assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> state_ff == S_MUL) else $error("load did not start");
   assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> !out_busy) else $error("finish while output busy");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.load, ctrl.mul, ctrl.sum, ctrl.finish})) else $error("ctrl overlap");
endmodule
`default_nettype wire

// ===== hw/rtl/rau_datapath.sv =====
`default_nettype none
module rau_datapath #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
   input  wire logic                       clock,
   input  wire logic [2:0]                 command,
   input  wire logic [31:0]                a_numerator,
   input  wire logic [31:0]                a_denominator,
   input  wire logic [31:0]                b_numerator,
   input  wire logic [31:0]                b_denominator,
   input  wire rau_pkg::ctrl_type          ctrl,
   output rau_pkg::stat_type               stat,
   output logic [rau_pkg::NumWidth-1:0]    result_numerator,
   output logic [rau_pkg::DenWidth-1:0]    result_denominator,
   output logic [1:0]                      status
);
   import rau_pkg::*;

   localparam int W = OPERAND_WIDTH;
   localparam int CntW = $clog2(MagWidth + 1);

   function automatic logic signed [31:0] take(input logic [31:0] raw);
      logic signed [W-1:0] v;
      v = raw[W-1:0];
      if (v == {1'b1, {(W-1){1'b0}}}) v = {1'b1, {(W-2){1'b0}}, 1'b1};
      return 32'(v);
   endfunction

   logic [2:0] cmd_ff;
   logic signed [31:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [63:0] p0_ff, p1_ff, p2_ff;
   logic neg_ff, early_ff;
   logic [1:0] st_ff;
   logic [MagWidth-1:0] nm_ff, dm_ff, x_ff, y_ff, q_ff, rem_ff, dvd_ff, g_ff;
   logic [CntW-1:0] cnt_ff, k_ff;
   logic [NumWidth-1:0] rn_ff;
   logic [DenWidth-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= command;
         an_ff <= take(a_numerator);
         ad_ff <= take(a_denominator);
         bn_ff <= take(b_numerator);
         bd_ff <= take(b_denominator);
      end
   end

   logic uses_b;
   logic signed [31:0] m0a, m0b, m1a, m1b, m2a, m2b;
   always_comb begin
      uses_b = cmd_ff <= 3'(CMD_DIV);
      m0a = an_ff; m0b = bd_ff;
      m1a = ad_ff; m1b = bn_ff;
      m2a = ad_ff; m2b = bd_ff;
      case (cmd_ff)
         3'(CMD_MUL): begin m0b = bn_ff; end
         3'(CMD_DIV): begin m2b = bn_ff; end
         3'(CMD_ADD), 3'(CMD_SUB): begin end
         default: begin m0b = 32'sd1; m2b = 32'sd1; end
      endcase
   end

   logic signed [63:0] num_w, den_w;
   always_comb begin
      case (cmd_ff)
         3'(CMD_ADD): num_w = p0_ff + p1_ff;
         3'(CMD_SUB): num_w = p0_ff - p1_ff;
         default: num_w = p0_ff;
      endcase
      den_w = p2_ff;
   end

   logic [63:0] nabs, dabs;
   assign nabs = num_w[63] ? 64'(-num_w) : 64'(num_w);
   assign dabs = den_w[63] ? 64'(-den_w) : 64'(den_w);

   logic [MagWidth-1:0] xr, yr;
   logic [MagWidth:0] trial;
   always_comb begin
      xr = x_ff - y_ff;
      yr = y_ff - x_ff;
      trial = {rem_ff, dvd_ff[MagWidth-1]} - {1'b0, g_ff};
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         p0_ff <= 64'(m0a * m0b);
         p1_ff <= 64'(m1a * m1b);
         p2_ff <= 64'(m2a * m2b);
      end
      if (ctrl.sum) begin
         nm_ff <= nabs[MagWidth-1:0];
         dm_ff <= dabs[MagWidth-1:0];
         x_ff <= dabs[MagWidth-1:0];
         y_ff <= nabs[MagWidth-1:0];
         k_ff <= '0;
         neg_ff <= num_w[63] ^ den_w[63];
         if (ad_ff == 0 || (uses_b && bd_ff == 0)) begin
            early_ff <= 1'b1; st_ff <= ST_ZERO_DEN;
         end else if (cmd_ff == 3'(CMD_DIV) && bn_ff == 0) begin
            early_ff <= 1'b1; st_ff <= ST_DIV_ZERO;
         end else begin
            early_ff <= nabs == 0; st_ff <= ST_OK;
         end
      end
      // binary gcd, common factors of two counted in k
      if (ctrl.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= xr >> 1;
         end else begin
            y_ff <= yr >> 1;
         end
      end
      if (ctrl.div_start) begin
         g_ff <= ctrl.div_num ? g_ff : (x_ff | y_ff) << k_ff;
         dvd_ff <= ctrl.div_num ? dm_ff : nm_ff;
         rem_ff <= '0;
         q_ff <= '0;
         cnt_ff <= CntW'(MagWidth);
         if (ctrl.div_num) begin
            rn_ff <= neg_ff ? NumWidth'(-{1'b0, q_ff}) : NumWidth'(q_ff);
         end
      end else if (ctrl.div_step) begin
         if (!trial[MagWidth]) begin
            rem_ff <= trial[MagWidth-1:0];
            q_ff <= {q_ff[MagWidth-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[MagWidth-2:0], dvd_ff[MagWidth-1]};
            q_ff <= {q_ff[MagWidth-2:0], 1'b0};
         end
         dvd_ff <= {dvd_ff[MagWidth-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (stat.div_done && !ctrl.div_num && !ctrl.div_step && !ctrl.div_start) begin
         rd_ff <= q_ff[DenWidth-1:0];
      end
   end

   always_comb begin
      stat.early = early_ff;
      stat.gcd_done = (x_ff == 0) || (y_ff == 0);
      stat.div_done = cnt_ff == 0;
      if (early_ff) begin
         result_numerator = '0;
         result_denominator = DenWidth'(1);
      end else begin
         result_numerator = rn_ff;
         result_denominator = rd_ff;
      end
      status = st_ff;
   end

   assert property (@(posedge clock)
      ctrl.div_step |-> cnt_ff != 0) else $error("divider overrun");
   assert property (@(posedge clock)
      ctrl.gcd_step |-> x_ff != 0 && y_ff != 0) else $error("gcd step after done");
   assert property (@(posedge clock)
      ctrl.div_start && !ctrl.div_num |-> (x_ff | y_ff) != 0) else $error("zero gcd");
endmodule
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
`default_nettype none
// sequence: multiply, sum, binary gcd, then the divider on the numerator and then on the
// denominator; a zero result or an error skips the gcd and the divides
// throughput: sequential, req_tready returns as the result enters the output register,
// which waits while the last result is not yet taken, so one request is handled at a time
// the binary gcd loop and the shared 63-step restoring divider run twice dominate the time
// reset: synchronous, clears the controller and output valid
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [135:0]  req_tdata,  // command, a_num, a_den, b_num, b_den
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata   // result_numerator, result_denominator, status
);
   import rau_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic idle, rsp_valid_ff;
   logic [NumWidth-1:0] rnum;
   logic [DenWidth-1:0] rden;
   logic [1:0] rst;
   logic [127:0] data_ff;

   assign req_tready = idle;

   rau_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(req_tvalid && req_tready),
      .out_busy(rsp_valid_ff && !rsp_tready), .stat(stat), .ctrl(ctrl), .idle(idle)
   );

   rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock(clock), .command(req_tdata[2:0]), .a_numerator(req_tdata[34:3]),
      .a_denominator(req_tdata[66:35]), .b_numerator(req_tdata[98:67]),
      .b_denominator(req_tdata[130:99]), .ctrl(ctrl), .stat(stat),
      .result_numerator(rnum), .result_denominator(rden), .status(rst)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.finish) data_ff <= {rst, rden, rnum};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = data_ff;
endmodule
`default_nettype wire

// ===== dv/rational_arithmetic_unit_test.sv =====
`default_nettype none
module rational_arithmetic_unit_test;
   import rau_pkg::*;

   typedef struct packed {
      logic [31:0] b_den;
      logic [31:0] b_num;
      logic [31:0] a_den;
      logic [31:0] a_num;
      logic [2:0]  command;
   } fraction_op_type;

   typedef struct {
      logic signed [63:0] numerator;
      logic [61:0]        denominator;
      status_type         status;
   } reduced_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [135:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;

   reduced_type   pending_fractions[$];
   int            error_count = 0;
   int            burst_left = 0;

   rational_arithmetic_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #80000000;
      $display("rational_arithmetic_unit_test: errors");
      $finish;
   end

   function automatic longint operand_of(logic [31:0] raw);
      longint v;
      v = longint'(signed'(raw));
      if (v < -64'sd2147483647) v = -64'sd2147483647;
      return v;
   endfunction

   function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic reduced_type reduce_fraction(fraction_op_type op);
      reduced_type r;
      longint an, ad, bn, bd, num, den;
      logic [63:0] nm, dm, g;
      logic uses_b;
      an = operand_of(op.a_num);
      ad = operand_of(op.a_den);
      bn = operand_of(op.b_num);
      bd = operand_of(op.b_den);
      uses_b = op.command <= CMD_DIV;
      r.numerator = 0;
      r.denominator = 1;
      r.status = ST_OK;
      if (ad == 0 || (uses_b && bd == 0)) begin
         r.status = ST_ZERO_DEN;
         return r;
      end
      if (op.command == CMD_DIV && bn == 0) begin
         r.status = ST_DIV_ZERO;
         return r;
      end
      case (op.command)
         CMD_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
         CMD_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
         CMD_MUL: begin num = an * bn; den = ad * bd; end
         CMD_DIV: begin num = an * bd; den = ad * bn; end
         default: begin num = an; den = ad; end
      endcase
      nm = num < 0 ? -num : num;
      dm = den < 0 ? -den : den;
      if (nm == 0) return r;
      g = gcd_of(nm, dm);
      nm = nm / g;
      dm = dm / g;
      r.numerator = ((num < 0) != (den < 0)) ? -nm : nm;
      r.denominator = dm[61:0];
      return r;
   endfunction

   task automatic send_fraction_op(fraction_op_type op);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tdata <= op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_fractions.push_back(reduce_fraction(op));
      burst_left--;
      @(negedge clock);
   endtask

   task automatic idle_sender;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
   endtask

   // receiver stall pattern
   initial begin
      forever begin
         @(negedge clock);
         case ($urandom_range(0, 3))
            0: rsp_tready <= 1'b0;
            1: rsp_tready <= ($urandom_range(0, 9) != 0);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      reduced_type e;
      logic signed [63:0] got_num;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_num = rsp_tdata[63:0];
         if (pending_fractions.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            e = pending_fractions.pop_front();
            if (got_num !== e.numerator) begin
               $error("result_numerator expected %0d actual %0d", e.numerator, got_num);
               error_count++;
            end
            if (rsp_tdata[125:64] !== e.denominator) begin
               $error("result_denominator expected %0d actual %0d",
                      e.denominator, rsp_tdata[125:64]);
               error_count++;
            end
            if (rsp_tdata[127:126] !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_tdata[127:126]);
               error_count++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) - 10;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000001;
         2: return 32'h80000000;
         3: return $urandom_range(1, 1000) * (1 << $urandom_range(0, 12));
         default: return $urandom();
      endcase
   endfunction

   function automatic fraction_op_type make_op(logic [2:0] c, logic [31:0] an,
                                               logic [31:0] ad, logic [31:0] bn,
                                               logic [31:0] bd);
      fraction_op_type op;
      op.command = c;
      op.a_num = an;
      op.a_den = ad;
      op.b_num = bn;
      op.b_den = bd;
      return op;
   endfunction

   task automatic test_directed;
      logic [31:0] mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      send_fraction_op(make_op(CMD_ADD, 1, 2, 1, 3));
      send_fraction_op(make_op(CMD_SUB, 1, 2, 1, 2));
      send_fraction_op(make_op(CMD_MUL, -3, 4, 8, -9));
      send_fraction_op(make_op(CMD_DIV, 6, -4, -3, 8));
      send_fraction_op(make_op(CMD_NORM, -12, -18, 0, 0));
      send_fraction_op(make_op(CMD_ADD, mx, 1, mx, 1));
      send_fraction_op(make_op(CMD_SUB, mn, 1, mx, 1));
      send_fraction_op(make_op(CMD_MUL, mx, mn, mn, mx - 1));
      send_fraction_op(make_op(CMD_DIV, mx, mx - 2, mn, 3));
      send_fraction_op(make_op(CMD_ADD, 1, mx, 1, mx - 1));
      send_fraction_op(make_op(CMD_NORM, mn, mx, 5, 5));
      send_fraction_op(make_op(CMD_ADD, 1, 0, 1, 1));
      send_fraction_op(make_op(CMD_MUL, 1, 1, 1, 0));
      send_fraction_op(make_op(CMD_NORM, 3, 0, 1, 1));
      send_fraction_op(make_op(CMD_NORM, 3, 7, 1, 0));
      send_fraction_op(make_op(CMD_DIV, 1, 2, 0, 3));
      send_fraction_op(make_op(CMD_DIV, 1, 0, 0, 3));
      send_fraction_op(make_op(CMD_MUL, 0, 5, 7, 3));
      send_fraction_op(make_op(3'd5, -8, 12, 1, 1));
      send_fraction_op(make_op(3'd6, 8, -12, 0, 0));
      send_fraction_op(make_op(3'd7, 0, mn, 0, 0));
      send_fraction_op(make_op(CMD_SUB, 0, 1, 0, 1));
      send_fraction_op(make_op(CMD_ADD, 32'hffffffff, mx, 32'h55555555, 32'haaaaaaab));
   endtask

   task automatic test_random_ops(int count);
      logic [2:0] c;
      for (int i = 0; i < count; i++) begin
         c = $urandom_range(0, 9) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4);
         send_fraction_op(make_op(c, rand_operand(), rand_operand(),
                                  rand_operand(), rand_operand()));
      end
   endtask

   task automatic test_drain_pause;
      int guard;
      idle_sender();
      guard = 0;
      while (pending_fractions.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      test_random_ops(20);
   endtask

   initial begin
      int guard;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_ops(700);
      test_drain_pause();
      test_random_ops(680);
      idle_sender();
      guard = 0;
      while (pending_fractions.size() != 0 && guard < 2000000) begin
         @(negedge clock);
         guard++;
      end
      repeat (600) @(negedge clock);
      if (error_count == 0 && pending_fractions.size() == 0) begin
         $display("rational_arithmetic_unit_test: clean");
      end else begin
         $display("rational_arithmetic_unit_test: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
